// ----- sv/hsd_pkg.sv -----
// Package for the Huffman stream decoder: sizes, phase and status codes,
// controller states, controller/datapath command and status structs. No dependencies.
package hsd_pkg;

  localparam int MaxLeaves = 128;
  localparam int NodeSlots = 256;
  localparam int NodeW     = 8;   // node index width
  localparam int StkW      = 7;   // stack index width
  localparam int SymW      = 7;

  localparam logic [1:0] ST_SYM  = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_LEAF = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_COUNT  = 3'd1,
    PH_SKIP   = 3'd2,
    PH_DATA   = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  // controller states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BIT   = 5'b00010,
    S_READ  = 5'b00100,
    S_OUT   = 5'b01000,
    S_FLUSH = 5'b10000
  } ctl_state_t;

  typedef struct packed {
    logic clear;      // stream_start: clear parse state
    logic load;       // latch accepted byte
    logic step;       // process current bit (data at read stage done)
    logic fetch;      // issue node-store read: walk node or child in data phase, else root
  } dp_cmd_t;

  typedef struct packed {
    logic       more;     // another bit to process in this byte
    logic       emit;     // step produced a result
    logic [1:0] emit_st;
    logic [SymW-1:0] emit_sym;
    logic       emit_fin;
    logic       stop;     // no further bits needed from this byte
    logic       need_rd;  // current bit needs a memory read before step
  } dp_stat_t;

endpackage

// ----- sv/hsd_datapath.sv -----
// Datapath: node store, node stack, parse registers, one bit per step.
// Depends on hsd_pkg.
module hsd_datapath
  import hsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  input  logic [7:0] byte_in,
  output dp_stat_t   stat
);

  // memories
  logic [23:0]       node_mem [NodeSlots];
  logic [NodeW-1:0]  stk_mem  [MaxLeaves];
  logic [23:0]       rd_data_r;

  phase_t            phase_r;
  logic [7:0]        stk_depth_r;
  logic [8:0]        nodes_used_r;
  logic [9:0]        leaf_bits_r;
  logic [2:0]        cnt_seen_r;
  logic [31:0]       left_r;
  logic [NodeW-1:0]  walk_r;
  logic [NodeW-1:0]  root_r;     // copy of stack bottom
  logic [NodeW-1:0]  top_r;      // copy of stack top
  logic [7:0]        sh_r;
  logic [3:0]        bits_r;     // bits left in byte
  logic              rd_sel_r;   // 0: walk node read, 1: child read
  logic [NodeW-1:0]  child_r;
  logic              bit_en_r;   // byte bits are parsed (header or data byte)

  logic bit_c;
  assign bit_c = sh_r[7];

  // child of the walk node for the current bit
  logic [NodeW-1:0] child_c;
  assign child_c = bit_c ? rd_data_r[7:0] : rd_data_r[15:8];

  // what the current bit needs
  logic wr_en;
  logic [NodeW-1:0] wr_addr;
  logic [23:0] wr_data;
  logic push_en, merge_en;
  logic [StkW-1:0] sp_addr;
  logic [NodeW-1:0] stk_rd_r;

  logic [9:0] lb_nxt;
  logic in_hdr, in_data;
  assign in_hdr  = bit_en_r && (phase_r == PH_HEADER);
  assign in_data = bit_en_r && (phase_r == PH_DATA);
  assign lb_nxt  = {leaf_bits_r[8:0], bit_c};

  always_comb begin
    stat          = '0;
    stat.more     = (bits_r > 4'd1);
    stat.emit_sym = '0;
    wr_en         = 1'b0;
    wr_addr       = nodes_used_r[NodeW-1:0];
    wr_data       = '0;
    push_en       = 1'b0;
    merge_en      = 1'b0;
    stat.need_rd  = in_data;
    if (in_hdr) begin
      if (leaf_bits_r != 10'd0) begin
        if (lb_nxt[7]) begin
          if (stk_depth_r >= 8'(MaxLeaves) || nodes_used_r >= 9'(NodeSlots)) begin
            stat.emit = 1'b1; stat.emit_st = ST_BAD;
          end else begin
            wr_en = 1'b1; wr_data = {1'b1, 16'd0, lb_nxt[6:0]}; push_en = 1'b1;
          end
        end
      end else if (!bit_c) begin
        if (stk_depth_r == 8'd0) begin
          stat.emit = 1'b1; stat.emit_st = ST_BAD;
        end else if (stk_depth_r == 8'd1) begin
          if (rd_data_r[23]) begin
            stat.emit = 1'b1; stat.emit_st = ST_LEAF;
          end else begin
            stat.stop = 1'b1;
          end
        end else if (nodes_used_r >= 9'(NodeSlots)) begin
          stat.emit = 1'b1; stat.emit_st = ST_BAD;
        end else begin
          wr_en = 1'b1; wr_data = {8'd0, stk_rd_r, top_r}; merge_en = 1'b1;
        end
      end
      if (stat.emit) stat.stop = 1'b1;
    end else if (in_data) begin
      if (rd_data_r[23]) begin
        stat.emit     = 1'b1;
        stat.emit_st  = ST_SYM;
        stat.emit_sym = rd_data_r[6:0];
        stat.emit_fin = (left_r == 32'd1);
        stat.stop     = (left_r == 32'd1);
      end
    end else begin
      stat.stop = 1'b1;
    end
    if (!stat.more) stat.stop = 1'b1;
  end

  // stack second-from-top address
  assign sp_addr = StkW'(stk_depth_r - 8'd2);

  // memories: node store written by header, read by walk or at root
  logic [NodeW-1:0] rd_addr;
  always_comb begin
    if (cmd.fetch && in_data) begin
      rd_addr = rd_sel_r ? child_c : walk_r;
    end else begin
      rd_addr = root_r;
    end
  end

  // in the data phase the read data is held between fetches
  always_ff @(posedge clk) begin
    if (wr_en && cmd.step) node_mem[wr_addr] <= wr_data;
    if (cmd.fetch || !in_data) rd_data_r <= node_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.step && push_en) stk_mem[StkW'(stk_depth_r)] <= nodes_used_r[NodeW-1:0];
    if (cmd.step && merge_en) stk_mem[sp_addr] <= nodes_used_r[NodeW-1:0];
    stk_rd_r <= stk_mem[sp_addr];
  end

  // parse registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; stk_depth_r <= '0; nodes_used_r <= '0;
      leaf_bits_r <= '0; cnt_seen_r <= '0; left_r <= '0; walk_r <= '0;
      root_r <= '0; top_r <= '0; bits_r <= '0; rd_sel_r <= 1'b0;
      bit_en_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        phase_r <= PH_HEADER; stk_depth_r <= '0; nodes_used_r <= '0;
        leaf_bits_r <= '0; cnt_seen_r <= '0; left_r <= '0; walk_r <= '0;
      end
      if (cmd.load) begin
        sh_r     <= byte_in;
        bits_r   <= 4'd8;
        rd_sel_r <= 1'b0;
        bit_en_r <= cmd.clear || (phase_r == PH_HEADER) || (phase_r == PH_DATA);
        case (cmd.clear ? PH_HEADER : phase_r)
          PH_COUNT: begin
            left_r <= left_r | (32'(byte_in) << {cnt_seen_r[1:0], 3'b000});
            cnt_seen_r <= cnt_seen_r + 3'd1;
            if (cnt_seen_r == 3'd3) phase_r <= PH_SKIP;
          end
          PH_SKIP: begin
            walk_r  <= root_r;
            phase_r <= (left_r != 32'd0) ? PH_DATA : PH_DONE;
          end
          default: ;
        endcase
      end
      if (cmd.fetch) begin
        rd_sel_r <= ~rd_sel_r;
        child_r  <= child_c;
      end
      if (cmd.step) begin
        sh_r   <= {sh_r[6:0], 1'b0};
        bits_r <= bits_r - 4'd1;
        rd_sel_r <= 1'b0;
        if (in_hdr) begin
          if (stat.emit) begin
            phase_r <= PH_ERROR;
          end else if (leaf_bits_r != 10'd0) begin
            leaf_bits_r <= lb_nxt[7] ? 10'd0 : lb_nxt;
            if (push_en) begin
              nodes_used_r <= nodes_used_r + 9'd1;
              stk_depth_r  <= stk_depth_r + 8'd1;
              top_r        <= nodes_used_r[NodeW-1:0];
              if (stk_depth_r == 8'd0) root_r <= nodes_used_r[NodeW-1:0];
            end
          end else if (bit_c) begin
            leaf_bits_r <= 10'd1;
          end else if (stk_depth_r == 8'd1) begin
            phase_r <= PH_COUNT; cnt_seen_r <= '0; left_r <= '0; walk_r <= root_r;
          end else if (merge_en) begin
            nodes_used_r <= nodes_used_r + 9'd1;
            stk_depth_r  <= stk_depth_r - 8'd1;
            top_r        <= nodes_used_r[NodeW-1:0];
            if (stk_depth_r == 8'd2) root_r <= nodes_used_r[NodeW-1:0];
          end
        end else if (in_data) begin
          if (rd_data_r[23]) begin
            left_r <= left_r - 32'd1;
            walk_r <= root_r;
            if (left_r == 32'd1) phase_r <= PH_DONE;
          end else begin
            walk_r <= child_r;
          end
        end
      end
    end
  end

  // top_r must stay valid across a merge: stack top after merge is the new node
`ifndef ASSERT_OFF
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    stk_depth_r <= 8'(MaxLeaves)) else $error("stack depth out of range");
  a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= 9'(NodeSlots)) else $error("node count out of range");
  a_done_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (left_r != 32'd0)) else $error("data phase with zero count");
`endif

endmodule

// ----- sv/hsd_ctrl.sv -----
// Controller: byte handshake, per-bit sequencing, result output register.
// Depends on hsd_pkg.
module hsd_ctrl
  import hsd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_start,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_data,
  output dp_cmd_t        cmd,
  input  dp_stat_t       stat
);

  ctl_state_t state_r, state_nxt;
  logic        ov_r, ov_nxt;
  logic [SymW-1:0] sym_r, sym_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        fin_r, fin_nxt, last_r, last_nxt;
  // newest result of the byte, held until it is known whether it is the last
  logic        pv_r, pv_nxt;
  logic [SymW-1:0] psym_r, psym_nxt;
  logic [1:0]  pst_r, pst_nxt;
  logic        pfin_r, pfin_nxt;
  logic        rd2_r;   // second read (child) issued in data phase

  logic out_free;
  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = {4'd0, last_r, fin_r, st_r, 1'b0, sym_r};

  // sequencer: IDLE -> READ (prime node read) -> BIT ... -> FLUSH (when a result is held) -> IDLE
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    ov_nxt   = ov_r && !out_ready;
    sym_nxt  = sym_r;
    st_nxt   = st_r;
    fin_nxt  = fin_r;
    last_nxt = last_r;
    pv_nxt   = pv_r;
    psym_nxt = psym_r;
    pst_nxt  = pst_r;
    pfin_nxt = pfin_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.clear = in_start;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // walk node read then child read (root read outside the data phase)
        cmd.fetch = 1'b1;
        if (rd2_r) state_nxt = S_BIT;
      end
      S_BIT: begin
        if (!stat.emit || !pv_r || out_free) begin
          cmd.step = 1'b1;
          if (stat.emit) begin
            // a newer result means the held one is not the last
            if (pv_r) begin
              ov_nxt   = 1'b1;
              sym_nxt  = psym_r;
              st_nxt   = pst_r;
              fin_nxt  = pfin_r;
              last_nxt = 1'b0;
            end
            pv_nxt   = 1'b1;
            psym_nxt = stat.emit_sym;
            pst_nxt  = stat.emit_st;
            pfin_nxt = stat.emit_fin;
          end
          if (stat.stop) state_nxt = (stat.emit || pv_r) ? S_FLUSH : S_IDLE;
          else state_nxt = stat.need_rd ? S_READ : S_OUT;
        end
      end
      S_OUT: begin
        // extra state so the stack read sees updated depth
        state_nxt = S_BIT;
      end
      S_FLUSH: begin
        // byte done: held result goes out as the last of the byte
        if (out_free) begin
          ov_nxt    = 1'b1;
          sym_nxt   = psym_r;
          st_nxt    = pst_r;
          fin_nxt   = pfin_r;
          last_nxt  = 1'b1;
          pv_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      pv_r    <= 1'b0;
      rd2_r   <= 1'b0;
      sym_r   <= '0;
      st_r    <= '0;
      fin_r   <= 1'b0;
      last_r  <= 1'b0;
      psym_r  <= '0;
      pst_r   <= '0;
      pfin_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.fetch) rd2_r <= ~rd2_r;
      ov_r    <= ov_nxt;
      sym_r   <= sym_nxt;
      st_r    <= st_nxt;
      fin_r   <= fin_nxt;
      last_r  <= last_nxt;
      pv_r    <= pv_nxt;
      psym_r  <= psym_nxt;
      pst_r   <= pst_nxt;
      pfin_r  <= pfin_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && stat.emit && pv_r) |-> out_free) else $error("result overwritten");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> pv_r) else $error("flush with nothing held");
`endif

endmodule

// ----- sv/huffman_stream_decoder_top.sv -----
// Top level of the Huffman stream decoder: controller plus datapath.
// Depends on hsd_pkg, hsd_ctrl, hsd_datapath.
//
// One compressed byte per request; the block takes one byte at a time. A data
// byte is accepted, then each bit takes a node-store read of the walk node, a
// read of the child and then the step, and FLUSH releases the last result of
// the byte. A header byte passes READ once, then a step and the S_OUT state per
// bit; count and skip bytes pass READ and BIT once. Output stalls can hold BIT
// and FLUSH. The registered node-store read sets this sequence.
module huffman_stream_decoder_top
  import hsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  input  logic        in_tuser,   // stream_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // symbol
  output logic [2:0]  out_tuser,  // status[1:0], final_symbol[2]
  output logic        out_tlast   // last_of_run
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [15:0] od;

  hsd_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_start(in_tuser), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(od),
    .cmd, .stat
  );

  hsd_datapath u_dp (
    .clk, .rst_n, .cmd, .byte_in(in_tdata), .stat
  );

  assign out_tdata = od[7:0];
  assign out_tuser = od[10:8];
  assign out_tlast = od[11];

endmodule

// ----- sim/tb_top.sv -----
// Testbench for huffman_stream_decoder_top: builds compressed streams, predicts
// every decoded symbol and header error, and checks each result on the output
// stream. Depends on hsd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import hsd_pkg::*;

  localparam int IdlePct   = 22;
  localparam int HoldLen   = 300;
  localparam int DrainWait = 40;
  localparam int StallMax  = 3000;

  typedef struct packed {
    logic [6:0] sym;
    logic [1:0] st;
    logic       fin;
    logic       last;
  } sym_result_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // in_byte
  logic       in_tuser = 1'b0; // stream_start
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // symbol
  logic [2:0] out_tuser;       // status[1:0], final_symbol[2]
  logic       out_tlast;       // last_of_run

  huffman_stream_decoder_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- decoder predictor ----------------
  logic [23:0] tree_mem[NodeSlots];
  logic [7:0]  build_stk[MaxLeaves];
  phase_t      parse_ph;
  int          stk_depth, nodes_alloc, leaf_acc, cnt_seen;
  logic [31:0] syms_left;
  logic [7:0]  walk_idx;
  sym_result_t pending_syms[$];
  int          fail_cnt = 0;
  int          bytes_sent = 0;

  function automatic void clear_parse();
    parse_ph = PH_HEADER;
    stk_depth = 0;
    nodes_alloc = 0;
    leaf_acc = 0;
    cnt_seen = 0;
    syms_left = '0;
    walk_idx = '0;
  endfunction

  // one header bit; returns an error status or ST_SYM for none
  function automatic logic [1:0] header_step(bit b);
    logic [7:0] rgt, lft;
    if (leaf_acc != 0) begin
      leaf_acc = ((leaf_acc << 1) | b) & 'h3FF;
      if (leaf_acc & 128) begin
        if (stk_depth >= MaxLeaves || nodes_alloc >= NodeSlots) begin
          leaf_acc = 0;
          return ST_BAD;
        end
        tree_mem[nodes_alloc] = {1'b1, 16'h0, 7'(leaf_acc)};
        leaf_acc = 0;
        build_stk[stk_depth] = 8'(nodes_alloc);
        stk_depth++;
        nodes_alloc++;
      end
      return ST_SYM;
    end
    if (b) begin
      leaf_acc = 1;
      return ST_SYM;
    end
    if (stk_depth == 0) return ST_BAD;
    if (stk_depth == 1) begin
      if (tree_mem[build_stk[0]][23]) return ST_LEAF;
      parse_ph = PH_COUNT;
      cnt_seen = 0;
      syms_left = '0;
      walk_idx = build_stk[0];
      return ST_SYM;
    end
    if (nodes_alloc >= NodeSlots) return ST_BAD;
    rgt = build_stk[stk_depth-1];
    lft = build_stk[stk_depth-2];
    tree_mem[nodes_alloc] = {8'h0, lft, rgt};
    stk_depth--;
    build_stk[stk_depth-1] = 8'(nodes_alloc);
    nodes_alloc++;
    return ST_SYM;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic start);
    sym_result_t r[$];
    logic [1:0]  st;
    logic [23:0] nd, cn;
    logic [7:0]  child;
    if (start) clear_parse();
    case (parse_ph)
      PH_COUNT: begin
        syms_left |= 32'(b) << (8 * (cnt_seen & 3));
        cnt_seen++;
        if (cnt_seen >= 4) parse_ph = PH_SKIP;
        return;
      end
      PH_SKIP: begin
        walk_idx = build_stk[0];
        parse_ph = (syms_left != 0) ? PH_DATA : PH_DONE;
        return;
      end
      PH_HEADER, PH_DATA: ;
      default: return;
    endcase
    for (int i = 7; i >= 0; i--) begin
      if (parse_ph == PH_HEADER) begin
        st = header_step(b[i]);
        if (st != ST_SYM) begin
          r.push_back('{sym: '0, st: st, fin: 1'b0, last: 1'b0});
          parse_ph = PH_ERROR;
          break;
        end
        if (parse_ph != PH_HEADER) break;
      end else if (parse_ph == PH_DATA) begin
        nd = tree_mem[walk_idx];
        child = b[i] ? nd[7:0] : nd[15:8];
        cn = tree_mem[child];
        if (cn[23]) begin
          syms_left--;
          r.push_back('{sym: cn[6:0], st: ST_SYM, fin: (syms_left == 0), last: 1'b0});
          walk_idx = build_stk[0];
          if (syms_left == 0) begin
            parse_ph = PH_DONE;
            break;
          end
        end else begin
          walk_idx = child;
        end
      end else begin
        break;
      end
    end
    if (r.size() > 0) r[r.size()-1].last = 1'b1;
    foreach (r[k]) pending_syms.push_back(r[k]);
  endfunction

  // ---------------- result side: checks and back-pressure ----------------
  logic no_idle  = 1'b0;
  logic hold_req = 1'b0;
  int   hold_cnt = 0;

  always @(posedge clk) begin
    sym_result_t e;
    if (out_tvalid && out_tready) begin
      if (pending_syms.size() == 0) begin
        $display("%0t: unexpected result: got sym=%0h st=%0d fin=%0b last=%0b", $time,
                 out_tdata, out_tuser[1:0], out_tuser[2], out_tlast);
        fail_cnt++;
      end else begin
        e = pending_syms.pop_front();
        if (out_tdata !== {1'b0, e.sym} || out_tuser[1:0] !== e.st ||
            out_tuser[2] !== e.fin || out_tlast !== e.last) begin
          $display("%0t: mismatch: expected sym=%0h st=%0d fin=%0b last=%0b, got sym=%0h st=%0d fin=%0b last=%0b",
                   $time, e.sym, e.st, e.fin, e.last,
                   out_tdata, out_tuser[1:0], out_tuser[2], out_tlast);
          fail_cnt++;
        end
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HoldLen;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IdlePct);
    end
  end

  // watchdog on cycles with no request moving on either side
  int stall_cyc = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cyc = 0;
    else stall_cyc++;
    if (stall_cyc > StallMax) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- stream builder ----------------
  logic [7:0] strm[$];
  bit         bitq[$];
  int         g_n;
  logic [6:0] g_sym[NodeSlots];
  int         g_par[NodeSlots];
  bit         g_side[NodeSlots];
  int         g_stk[$];
  int         g_leaves[$];

  task automatic put_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) bitq.push_back(v[i]);
  endtask

  task automatic flush_bits();
    logic [7:0] by;
    while (bitq.size() % 8 != 0) bitq.push_back($urandom_range(1));
    for (int i = 0; i < bitq.size(); i += 8) begin
      for (int j = 0; j < 8; j++) by[7-j] = bitq[i+j];
      strm.push_back(by);
    end
    bitq.delete();
  endtask

  // post-order header; chain keeps the stack at most two deep
  task automatic gen_tree(int nleaves, bit chain, bit ext);
    int left, l, r;
    logic [6:0] s;
    g_n = 0;
    left = nleaves;
    g_stk.delete();
    g_leaves.delete();
    while (left > 0 || g_stk.size() > 1) begin
      if (left > 0 && (g_stk.size() < 2 || (!chain && $urandom_range(1)))) begin
        s = 7'($urandom);
        if (ext) s = (left == nleaves) ? 7'd0 : (left == 1) ? 7'h7F : s;
        put_bits({1'b1, s}, 8);
        g_sym[g_n] = s;
        g_stk.push_back(g_n);
        g_leaves.push_back(g_n);
        g_n++;
        left--;
      end else begin
        r = g_stk.pop_back();
        l = g_stk.pop_back();
        g_par[l] = g_n; g_side[l] = 1'b0;
        g_par[r] = g_n; g_side[r] = 1'b1;
        g_stk.push_back(g_n);
        g_n++;
        put_bits(0, 1);
      end
    end
  endtask

  task automatic make_stream(int nleaves, int nsyms, logic [31:0] cnt, bit ext);
    int  nd;
    bit  path[$];
    strm.delete();
    gen_tree(nleaves, 1'b0, ext);
    put_bits(0, 1);
    flush_bits();
    for (int i = 0; i < 4; i++) strm.push_back(cnt[8*i +: 8]);
    strm.push_back(8'($urandom));
    for (int k = 0; k < nsyms; k++) begin
      nd = g_leaves[$urandom_range(g_leaves.size() - 1)];
      path.delete();
      while (nd != g_n - 1) begin
        path.push_front(g_side[nd]);
        nd = g_par[nd];
      end
      foreach (path[j]) bitq.push_back(path[j]);
    end
    flush_bits();
    repeat ($urandom_range(2)) strm.push_back(8'($urandom));
  endtask

  // ---------------- sender ----------------
  task automatic send_byte(logic [7:0] b, logic start);
    if (!no_idle && $urandom_range(99) < IdlePct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, start);
    bytes_sent++;
  endtask

  task automatic send_stream(logic start, int limit);
    foreach (strm[i]) begin
      if (i >= limit) break;
      send_byte(strm[i], (i == 0) ? start : 1'b0);
    end
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_syms.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // ---------------- tests ----------------
  task automatic test_no_start();
    make_stream(3, 5, 5, 1'b0);
    send_stream(1'b0, strm.size());
    wait_drain();
  endtask

  task automatic test_extremes();
    make_stream(6, 12, 12, 1'b1);
    send_stream(1'b1, strm.size());
    // bytes after the final symbol are ignored until a new start
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_drain();
  endtask

  task automatic test_header_cases();
    send_byte(8'h00, 1'b1);        // merge with nothing stacked
    send_byte(8'hAA, 1'b0);        // ignored in the error phase
    send_byte(8'h80, 1'b1);        // lone leaf, symbol 0
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);        // lone leaf, symbol 127
    send_byte(8'h00, 1'b0);
    make_stream(2, 0, 0, 1'b0);    // zero symbol count
    send_stream(1'b1, strm.size());
    make_stream(4, 10, 10, 1'b0);  // restart in the middle of a stream
    send_stream(1'b1, 8);
    make_stream(3, 8, 32'hFFFF_FFFF, 1'b0);  // count that never runs out
    send_stream(1'b1, strm.size());
    wait_drain();
  endtask

  task automatic test_stack_overflow();
    strm.delete();
    repeat (MaxLeaves + 1) put_bits({1'b1, 7'($urandom)}, 8);
    flush_bits();
    send_stream(1'b1, strm.size());
    wait_drain();
  endtask

  task automatic test_node_overflow();
    strm.delete();
    gen_tree(MaxLeaves, 1'b1, 1'b0);
    put_bits({1'b1, 7'($urandom)}, 8);
    put_bits(0, 1);
    flush_bits();
    send_stream(1'b1, strm.size());
    wait_drain();
  endtask

  // receiver holds off while one-bit codes fill the block
  task automatic test_backpressure();
    hold_req = 1'b1;
    make_stream(2, 80, 80, 1'b0);
    send_stream(1'b1, strm.size());
    wait_drain();
  endtask

  task automatic test_random();
    int base, done_n, r;
    base = bytes_sent;
    done_n = 0;
    while (done_n < 40) begin
      no_idle = (done_n >= 10 && done_n < 30);
      r = $urandom_range(99);
      if (r < 12) begin
        send_byte(8'($urandom), 1'b1);
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
      end else if (r < 20) begin
        make_stream($urandom_range(2, 8), $urandom_range(1, 14), 0, 1'b0);
        strm[4 + $urandom_range(1)] = 8'($urandom);
        send_stream(1'b1, $urandom_range(1, strm.size()));
      end else begin
        make_stream((r < 26) ? $urandom_range(20, 60) : $urandom_range(2, 8),
                    r % 15, r % 15, 1'b0);
        send_stream(1'b1, strm.size());
      end
      done_n = bytes_sent - base;
    end
    no_idle = 1'b0;
    wait_drain();
  endtask

  initial begin
    foreach (tree_mem[i]) tree_mem[i] = '0;
    foreach (build_stk[i]) build_stk[i] = '0;
    clear_parse();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_start();
    test_extremes();
    test_header_cases();
    test_stack_overflow();
    test_node_overflow();
    test_backpressure();
    test_random();
    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
